[rtl/spc_pkg.sv]
// Shared types and constants for the set-partition canonical code block.
// Holds the request and response words and the microcode control word.
// No dependencies.
package spc_pkg;

   localparam int MASK_W    = 32;   // width of a class mask word
   localparam int POS_W     = 5;    // bit position field
   localparam int POS_COUNT = 32;   // positions tracked by the owner table
   localparam int LABEL_W   = 4;    // label field on the response
   localparam int TAG_W     = 5;    // stored first-appearance label
   localparam int LEN_W     = 6;    // bit length, 0..32
   localparam int PC_W      = 2;    // microcode step counter

   typedef struct packed {
      logic [MASK_W-1:0] class_mask;
      logic              last_class;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [LABEL_W-1:0] label;
      logic               unowned;
      logic               overflow;
      logic               last_label;
   } rsp_word_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_REQ_LAST,
      COND_EMIT_END
   } cond_type;

   // One control word per microcode step.
   typedef struct packed {
      logic            load;     // take request words
      logic            size;     // latch bit length, rewind position
      logic            emit;     // produce one label word per free slot
      logic            clear;    // drop partition state
      cond_type        cond;     // jump condition
      logic            hold;     // stay on this step while cond is false
      logic [PC_W-1:0] target;   // jump target
   } ucode_type;

   typedef struct packed {
      logic req_last_fire;       // last class word taken this cycle
      logic emit_end;            // final label word produced this cycle
   } status_type;

   localparam logic [PC_W-1:0] STEP_LOAD  = 2'd0;
   localparam logic [PC_W-1:0] STEP_SIZE  = 2'd1;
   localparam logic [PC_W-1:0] STEP_EMIT  = 2'd2;
   localparam logic [PC_W-1:0] STEP_CLEAR = 2'd3;

endpackage

[rtl/spc_sequencer.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on spc_pkg.
module spc_sequencer
   import spc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ucode_type  ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            take;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      begin
         w = '0;
         case (pc)
            STEP_LOAD: begin
               w.load = 1'b1;  w.cond = COND_REQ_LAST; w.hold = 1'b1;
               w.target = STEP_SIZE;
            end
            STEP_SIZE: begin
               w.size = 1'b1;  w.cond = COND_ALWAYS;   w.target = STEP_EMIT;
            end
            STEP_EMIT: begin
               w.emit = 1'b1;  w.cond = COND_EMIT_END; w.hold = 1'b1;
               w.target = STEP_CLEAR;
            end
            STEP_CLEAR: begin
               w.clear = 1'b1; w.cond = COND_ALWAYS;   w.target = STEP_LOAD;
            end
            default: begin
               w.cond = COND_ALWAYS; w.target = STEP_LOAD;
            end
         endcase
         return w;
      end
   endfunction

   // The control word depends on the step counter alone.
   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   take = 1'b1;
         COND_REQ_LAST: take = status.req_last_fire;
         COND_EMIT_END: take = status.emit_end;
         default:       take = 1'b0;
      endcase
      if (take) begin
         pc_in = ctrl.target;
      end else if (ctrl.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[rtl/spc_datapath.sv]
// Datapath: per-position owner table, label map and scan position.
// Depends on spc_pkg; driven by the control word of spc_sequencer.
module spc_datapath
   import spc_pkg::*;
#(
   parameter int MAX_CLASSES = 16,
   parameter int MASK_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  ucode_type    ctrl,
   input  logic         req_fire,
   input  req_word_type req_word,
   input  logic         emit_fire,
   output rsp_word_type emit_word,
   output status_type   status
);

   localparam int MASK_EFF = (MASK_BITS < MASK_W) ? MASK_BITS : MASK_W;
   localparam int CW       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int NW       = $clog2(MAX_CLASSES + 1);

   logic [NW-1:0]     count_ff;
   logic [MASK_W-1:0] union_ff;
   logic              overflow_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CW-1:0]     owner_ff [POS_COUNT];
   logic              owned_ff [POS_COUNT];
   logic [TAG_W-1:0]  tag_ff [MAX_CLASSES];
   logic              tag_valid_ff [MAX_CLASSES];
   logic [TAG_W-1:0]  next_tag_ff;

   logic [MASK_W-1:0] mask_lim;
   logic [MASK_W-1:0] masked;
   logic              room;
   logic [CW-1:0]     own;
   logic              hit;
   logic              seen;
   logic [TAG_W-1:0]  tag;
   logic              is_last;

   function automatic logic [LEN_W-1:0] length_of(input logic [MASK_W-1:0] x);
      logic [LEN_W-1:0] n;
      begin
         n = '0;
         for (int i = 0; i < MASK_W; i++) begin
            if (x[i]) n = LEN_W'(i + 1);
         end
         return n;
      end
   endfunction

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         mask_lim[i] = (i < MASK_EFF);
      end
      masked  = req_word.class_mask & mask_lim;
      room    = (count_ff < NW'(MAX_CLASSES));
      own     = owner_ff[pos_ff];
      hit     = owned_ff[pos_ff];
      seen    = tag_valid_ff[own];
      tag     = seen ? tag_ff[own] : next_tag_ff;
      is_last = ({1'b0, pos_ff} + 1'b1) == len_ff;

      emit_word.position   = pos_ff;
      emit_word.label      = hit ? tag[LABEL_W-1:0] : '0;
      emit_word.unowned    = !hit;
      emit_word.overflow   = overflow_ff;
      emit_word.last_label = is_last;

      status.req_last_fire = req_fire && req_word.last_class;
      status.emit_end      = emit_fire && is_last;
   end

   // Payload-like registers: written before they are read.
   always_ff @(posedge clock) begin
      if (req_fire && room) begin
         for (int p = 0; p < POS_COUNT; p++) begin
            if (masked[p]) owner_ff[p] <= count_ff[CW-1:0];
         end
      end
      if (ctrl.size) begin
         len_ff <= length_of(union_ff | MASK_W'(1));
      end
      if (emit_fire && hit && !seen) begin
         tag_ff[own] <= next_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         count_ff    <= '0;
         union_ff    <= '0;
         overflow_ff <= 1'b0;
         next_tag_ff <= '0;
         for (int p = 0; p < POS_COUNT; p++) owned_ff[p] <= 1'b0;
         for (int c = 0; c < MAX_CLASSES; c++) tag_valid_ff[c] <= 1'b0;
      end else begin
         if (req_fire) begin
            if (room) begin
               count_ff <= count_ff + 1'b1;
               union_ff <= union_ff | masked;
               for (int p = 0; p < POS_COUNT; p++) begin
                  if (masked[p]) owned_ff[p] <= 1'b1;
               end
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (emit_fire && hit && !seen) begin
            tag_valid_ff[own] <= 1'b1;
            next_tag_ff       <= next_tag_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.size) begin
         pos_ff <= '0;
      end else if (emit_fire) begin
         pos_ff <= pos_ff + 1'b1;
      end
   end

endmodule

[rtl/set_partition_canonical_code.sv]
// Set-partition canonical code (restricted growth string) generator.
// Request channel (req_*): one class mask word per cycle while loading; a word
//   with last_class set closes the partition. Classes beyond MAX_CLASSES are
//   dropped and set the overflow flag of that partition's labels.
// Response channel (rsp_*): one word per scanned bit position, from 0 up to
//   the bit length (at least 1) of the widest stored mask minus one, last_label on the final.
//   Each word gives the first-appearance label of the owning class (later
//   class wins on overlap), or unowned with label 0.
// Sequence: loading takes one class word per cycle while req_valid is high.
//   After the last class, the length step latches the bit length, then the
//   label step emits one label word per position into the output register,
//   then the clear step clears the partition.
// The rate is set by the microcode step counter: one step per cycle unless a
//   step holds on its condition, the label step repeating once per position.
// Stall: the output register holds a word until rsp_ready; the label step waits
//   on it. req_ready is low from the last class until the partition is cleared.
// Reset: synchronous, active high; clears the step counter, fill count, owner
//   and label valid bits, and drops any pending response word.
// Depends on spc_pkg, spc_sequencer and spc_datapath.
module set_partition_canonical_code
   import spc_pkg::*;
#(
   parameter int MAX_CLASSES = 16,
   parameter int MASK_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   ucode_type    ctrl;
   status_type   status;
   rsp_word_type emit_word;
   logic         req_fire;
   logic         emit_fire;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   // Take words only on the load step; emit when the output slot is free.
   assign req_ready = ctrl.load;
   assign req_fire  = req_valid && req_ready;
   assign emit_fire = ctrl.emit && (!rsp_valid_ff || rsp_ready);

   spc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   spc_datapath #(
      .MAX_CLASSES (MAX_CLASSES),
      .MASK_BITS   (MASK_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_fire  (req_fire),
      .req_word  (req_word),
      .emit_fire (emit_fire),
      .emit_word (emit_word),
      .status    (status)
   );

   // Output register: load on emit, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_word_ff <= emit_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // The last class moves the sequencer to the length step.
   a_last_to_size: assert property (@(posedge clock) disable iff (reset)
      status.req_last_fire |=> ctrl.size)
      else $error("last class did not start the length step");

   // The final label word is followed by the clear step.
   a_end_to_clear: assert property (@(posedge clock) disable iff (reset)
      status.emit_end |=> ctrl.clear)
      else $error("final label not followed by clear");

   // Positions advance by one between consecutive label words of a partition.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !status.emit_end) ##1 emit_fire
         |-> emit_word.position == $past(emit_word.position) + 1'b1)
      else $error("label position skipped");

   // No class word is taken while labels are being produced.
   a_no_load_in_emit: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> !req_ready)
      else $error("request taken during emission");
`endif

endmodule
